FILE: src/lsh_pkg.sv
// Shared types, codes and default sizes of the log-scaled histogram engine.
package lsh_pkg;

    localparam int NUM_BINS_DEF     = 256;
    localparam int LINEAR_LIMIT_DEF = 10;
    localparam int COUNTER_BITS_DEF = 48;

    localparam int SAMPLE_W   = 32;
    localparam int READ_BIN_W = 8;
    localparam int BIN_NUM_W  = 8;
    localparam int TOTAL_W    = 48;
    localparam int THR_W      = 34;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SEARCH,
        ST_CHECK,
        ST_READ,
        ST_RESP
    } lsh_state_t;

    typedef enum logic {
        OP_ADD  = 1'b0,
        OP_READ = 1'b1
    } lsh_op_t;

    typedef struct packed {
        logic load;
        logic step;
        logic clr_wr;
        logic rd_en;
        logic commit;
        logic drop;
    } lsh_cmd_t;

    typedef struct packed {
        logic is_read;
        logic is_linear;
        logic step_last;
        logic in_range;
        logic clr_last;
    } lsh_status_t;

endpackage

FILE: src/log_scaled_histogram.sv
// Log-scaled histogram engine: controller and datapath with the counter store.
// Each item steps through the states in order: a read through READ and RESP, an add up to
// LINEAR_LIMIT through CHECK, READ and RESP, a larger add first through the search in SEARCH,
// one threshold per cycle; an add that maps past the table ends in CHECK. READ and RESP make
// the read-then-write pass on the single counter port.
// A new item can be taken while done is high; the receiver cannot stall results.
// After reset a clearing sweep zeroes the store with busy held high.
module log_scaled_histogram #(
    parameter int NUM_BINS     = lsh_pkg::NUM_BINS_DEF,
    parameter int LINEAR_LIMIT = lsh_pkg::LINEAR_LIMIT_DEF,
    parameter int COUNTER_BITS = lsh_pkg::COUNTER_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           operation,
    input  logic [lsh_pkg::SAMPLE_W-1:0]   sample_count,
    input  logic [lsh_pkg::READ_BIN_W-1:0] read_bin,
    output logic                           done,
    output logic [lsh_pkg::BIN_NUM_W-1:0]  bin_number,
    output logic [lsh_pkg::TOTAL_W-1:0]    bin_total,
    output logic                           out_of_range,
    output logic [lsh_pkg::BIN_NUM_W-1:0]  highest_bin,
    output logic                           none_counted
);
    import lsh_pkg::*;

    lsh_cmd_t    cmd;
    lsh_status_t status;

    lsh_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    lsh_datapath #(
        .NUM_BINS     (NUM_BINS),
        .LINEAR_LIMIT (LINEAR_LIMIT),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .operation    (operation),
        .sample_count (sample_count),
        .read_bin     (read_bin),
        .bin_number   (bin_number),
        .bin_total    (bin_total),
        .out_of_range (out_of_range),
        .highest_bin  (highest_bin),
        .none_counted (none_counted)
    );

    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without an item in progress");

    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    a_drop_zero_total: assert property (@(posedge clk) disable iff (!rst_n)
        (done && out_of_range) |-> (bin_total == '0))
        else $error("dropped item reported a nonzero total");

    a_empty_zero_total: assert property (@(posedge clk) disable iff (!rst_n)
        (done && none_counted) |-> (bin_total == '0))
        else $error("nonzero total while nothing has been counted");

endmodule

FILE: src/lsh_ctrl.sv
// Controller state machine of the log-scaled histogram engine.
module lsh_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  lsh_pkg::lsh_status_t status,
    output lsh_pkg::lsh_cmd_t   cmd,
    output logic                busy,
    output logic                done
);
    import lsh_pkg::*;

    lsh_state_t state_reg, state_next;
    logic       done_reg, done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (status.clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (status.is_read)
                        state_next = ST_READ;
                    else if (status.is_linear)
                        state_next = ST_CHECK;
                    else
                        state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                cmd.step = 1'b1;
                if (status.step_last)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (status.in_range)
                    state_next = ST_READ;
                else
                begin
                    // drop the item and report it
                    cmd.drop   = 1'b1;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                cmd.commit = 1'b1;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

FILE: src/lsh_datapath.sv
// Datapath: threshold search, counter memory with saturating update, result registers.
module lsh_datapath #(
    parameter int NUM_BINS     = lsh_pkg::NUM_BINS_DEF,
    parameter int LINEAR_LIMIT = lsh_pkg::LINEAR_LIMIT_DEF,
    parameter int COUNTER_BITS = lsh_pkg::COUNTER_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  lsh_pkg::lsh_cmd_t              cmd,
    output lsh_pkg::lsh_status_t           status,
    input  logic                           operation,
    input  logic [lsh_pkg::SAMPLE_W-1:0]   sample_count,
    input  logic [lsh_pkg::READ_BIN_W-1:0] read_bin,
    output logic [lsh_pkg::BIN_NUM_W-1:0]  bin_number,
    output logic [lsh_pkg::TOTAL_W-1:0]    bin_total,
    output logic                           out_of_range,
    output logic [lsh_pkg::BIN_NUM_W-1:0]  highest_bin,
    output logic                           none_counted
);
    import lsh_pkg::*;

    localparam int IW    = $clog2(NUM_BINS);
    localparam int TW    = $clog2(NUM_BINS + 1);
    localparam int LW    = $clog2(LINEAR_LIMIT + 1);
    localparam int BW    = (TW > LW) ? TW : LW;
    localparam int SPAN  = (NUM_BINS > LINEAR_LIMIT) ? NUM_BINS - LINEAR_LIMIT : 1;
    localparam int PW    = $clog2(SPAN + 1);
    localparam int SCW   = (PW > 1) ? $clog2(PW) : 1;
    localparam int SW    = BW + 1;
    localparam int CW    = (BW > READ_BIN_W) ? BW : READ_BIN_W;
    localparam int XW    = (BW > BIN_NUM_W) ? BW : BIN_NUM_W;
    localparam int VW    = (COUNTER_BITS > TOTAL_W) ? COUNTER_BITS : TOTAL_W;

    typedef logic [THR_W-1:0] thr_t;
    typedef thr_t thr_arr_t [NUM_BINS+1];

    localparam thr_t THR_NEVER = thr_t'(64'd1 << 33);
    localparam logic [BIN_NUM_W-1:0] LAST_BIN8 = BIN_NUM_W'(NUM_BINS - 1);
    localparam logic [VW-1:0] TOT_MAX_X = VW'({TOTAL_W{1'b1}});

    // Long division by shift and subtract; used only while elaborating the table.
    function automatic logic [63:0] udiv64(logic [63:0] a, logic [63:0] b);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[63:0], a[i]};
            if (rem >= {1'b0, b})
            begin
                rem  = rem - {1'b0, b};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // exp(1/d) in Q2.62 from a truncated Taylor series
    function automatic logic [63:0] exp_inv(logic [63:0] d);
        logic [63:0] term;
        logic [63:0] sum;
        term = 64'd1 << 62;
        sum  = 64'd1 << 62;
        for (int n = 1; n <= 40; n++)
        begin
            if (term != '0)
            begin
                term = udiv64(term, 64'(n) * d);
                sum  = sum + term;
            end
        end
        return sum;
    endfunction

    // Smallest count per bin, from a Q64.64 running product truncated at every step.
    function automatic thr_arr_t build_thr();
        thr_arr_t     t;
        logic [63:0]  h;
        logic [63:0]  m;
        logic [127:0] r;
        logic [191:0] p;
        logic         past;
        for (int j = 0; j <= NUM_BINS; j++)
            t[j] = THR_NEVER;
        h    = exp_inv(64'(2 * LINEAR_LIMIT));
        m    = exp_inv(64'(LINEAR_LIMIT));
        r    = 128'(h) << 2;
        p    = 192'(r) * 192'(LINEAR_LIMIT);
        r    = p[127:0];
        past = 1'b0;
        for (int j = LINEAR_LIMIT + 1; j <= NUM_BINS; j++)
        begin
            if (!past && r[127:96] == '0)
            begin
                t[j] = thr_t'(r[95:64]) + thr_t'(r[63:0] != '0);
                p    = 192'(r) * 192'(m);
                r    = p[189:62];
            end
            else
            begin
                past = 1'b1;
                t[j] = THR_NEVER;
            end
        end
        return t;
    endfunction

    localparam thr_arr_t THR = build_thr();

    logic                    op_reg;
    logic [SAMPLE_W-1:0]     k_reg;
    logic [BW-1:0]           bin_reg;
    logic [PW-1:0]           pos_reg;
    logic [SCW-1:0]          step_reg;
    logic [IW-1:0]           clr_reg;
    logic [COUNTER_BITS-1:0] rdata_reg;
    logic [IW-1:0]           top_reg, top_next;
    logic                    any_reg, any_next;

    logic [BIN_NUM_W-1:0]    bin_number_reg;
    logic [TOTAL_W-1:0]      bin_total_reg;
    logic                    out_of_range_reg;
    logic [BIN_NUM_W-1:0]    highest_bin_reg;
    logic                    none_counted_reg;

    logic [COUNTER_BITS-1:0] counters [NUM_BINS];

    logic [CW-1:0]           rb_wide;
    logic [CW-1:0]           rb_clamp;
    logic [PW-1:0]           cand;
    logic [SW-1:0]           idx_sum;
    logic                    cand_ok;
    logic [TW-1:0]           tidx;
    logic                    hit;
    logic [PW-1:0]           pos_new;
    logic [IW-1:0]           bin_idx;
    logic                    wr_en;
    logic [COUNTER_BITS-1:0] inc;
    logic [COUNTER_BITS-1:0] cval;
    logic [VW-1:0]           cval_x;
    logic [TOTAL_W-1:0]      total_sat;
    logic [XW-1:0]           bin_x;
    logic [XW-1:0]           top_x;
    logic [XW-1:0]           top_cur_x;

    assign rb_wide  = CW'(read_bin);
    assign rb_clamp = (rb_wide >= CW'(NUM_BINS)) ? CW'(NUM_BINS - 1) : rb_wide;

    // one bit of the bin offset per search step, highest bit first
    assign cand    = pos_reg | (PW'(1) << step_reg);
    assign idx_sum = SW'(LINEAR_LIMIT) + SW'(cand);
    assign cand_ok = (idx_sum <= SW'(NUM_BINS));
    assign tidx    = cand_ok ? idx_sum[TW-1:0] : '0;
    assign hit     = cand_ok && ({2'b00, k_reg} >= THR[tidx]);
    assign pos_new = hit ? cand : pos_reg;

    assign bin_idx = bin_reg[IW-1:0];
    assign wr_en   = cmd.commit && (op_reg == OP_ADD);
    assign inc     = (&rdata_reg) ? rdata_reg : rdata_reg + 1'b1;
    assign cval    = (op_reg == OP_ADD) ? inc : rdata_reg;
    assign cval_x  = VW'(cval);
    assign total_sat = (cval_x > TOT_MAX_X) ? '1 : cval_x[TOTAL_W-1:0];

    always_comb
    begin
        top_next = top_reg;
        any_next = any_reg;
        if (wr_en)
        begin
            if (!any_reg || bin_idx > top_reg)
                top_next = bin_idx;
            any_next = 1'b1;
        end
    end

    assign bin_x     = XW'(bin_reg);
    assign top_x     = XW'(top_next);
    assign top_cur_x = XW'(top_reg);

    assign status.is_read   = (operation == OP_READ);
    assign status.is_linear = (sample_count <= SAMPLE_W'(LINEAR_LIMIT));
    assign status.step_last = (step_reg == '0);
    assign status.in_range  = (bin_reg < BW'(NUM_BINS));
    assign status.clr_last  = (clr_reg == IW'(NUM_BINS - 1));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= operation;
            k_reg    <= sample_count;
            pos_reg  <= '0;
            step_reg <= SCW'(PW - 1);
            if (operation == OP_READ)
                bin_reg <= rb_clamp[BW-1:0];
            else if (sample_count <= SAMPLE_W'(LINEAR_LIMIT))
                bin_reg <= sample_count[BW-1:0];
            else
                bin_reg <= BW'(LINEAR_LIMIT);
        end
        else if (cmd.step)
        begin
            pos_reg  <= pos_new;
            step_reg <= step_reg - 1'b1;
            bin_reg  <= BW'(LINEAR_LIMIT) + BW'(pos_new);
        end
    end

    // counter store: clearing sweep, write on add, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.clr_wr)
            counters[clr_reg] <= '0;
        else if (wr_en)
            counters[bin_idx] <= inc;
        if (cmd.rd_en)
            rdata_reg <= counters[bin_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
            top_reg <= '0;
            any_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_wr)
                clr_reg <= clr_reg + 1'b1;
            top_reg <= top_next;
            any_reg <= any_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.drop)
        begin
            bin_number_reg   <= LAST_BIN8;
            bin_total_reg    <= '0;
            out_of_range_reg <= 1'b1;
            highest_bin_reg  <= top_cur_x[BIN_NUM_W-1:0];
            none_counted_reg <= !any_reg;
        end
        else if (cmd.commit)
        begin
            bin_number_reg   <= bin_x[BIN_NUM_W-1:0];
            bin_total_reg    <= total_sat;
            out_of_range_reg <= 1'b0;
            highest_bin_reg  <= top_x[BIN_NUM_W-1:0];
            none_counted_reg <= !any_next;
        end
    end

    assign bin_number   = bin_number_reg;
    assign bin_total    = bin_total_reg;
    assign out_of_range = out_of_range_reg;
    assign highest_bin  = highest_bin_reg;
    assign none_counted = none_counted_reg;

endmodule
